### rtl/core/rfcs_pkg.sv
// Shared types, message constants and the bit-level microcode for the command serializer.
package rfcs_pkg;

    localparam int FREQ_W     = 37;
    localparam int TPB_W      = 16;
    localparam int BYTE_POS_W = 6;
    localparam int STEP_W     = 4;
    localparam int LIMIT_W    = 48;
    localparam int CLEAN_LEN  = 24;
    localparam int UCODE_DEPTH = 10;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic REG_LINK_ENABLE   = 1'b0;
    localparam logic REG_TICKS_PER_BIT = 1'b1;

    localparam logic [STEP_W-1:0] STEP_START = 4'd0;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [3:0] DIGIT_HIGH = 4'h3;

    // Cleanup string ";SB0;FR0;FT0;RT0;XT0;RC;"
    localparam logic [7:0] CLEAN_STR [CLEAN_LEN] = '{
        8'h3B, 8'h53, 8'h42, 8'h30, 8'h3B, 8'h46, 8'h52, 8'h30,
        8'h3B, 8'h46, 8'h54, 8'h30, 8'h3B, 8'h52, 8'h54, 8'h30,
        8'h3B, 8'h58, 8'h54, 8'h30, 8'h3B, 8'h52, 8'h43, 8'h3B
    };

    typedef struct packed {
        logic              mode;
        logic [FREQ_W-1:0] freq_hz;
    } req_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic sequence_done;
        logic request_rejected;
    } res_t;

    typedef struct packed {
        logic             link_enable;
        logic [TPB_W-1:0] ticks_per_bit;
    } cfg_t;

    typedef enum logic [1:0] {
        PIN_MARK  = 2'b00,
        PIN_SPACE = 2'b01,
        PIN_DATA  = 2'b10
    } pin_sel_t;

    // One control word per bit step, applied when the current bit time ends.
    typedef struct packed {
        logic [STEP_W-1:0] next_step;
        pin_sel_t          pin_sel;
        logic              shift_en;
        logic              end_of_byte;
    } ucode_t;

    localparam ucode_t UCODE_ROM [UCODE_DEPTH] = '{
        '{4'd1, PIN_DATA,  1'b1, 1'b0},  // start bit ends: first data bit
        '{4'd2, PIN_DATA,  1'b1, 1'b0},
        '{4'd3, PIN_DATA,  1'b1, 1'b0},
        '{4'd4, PIN_DATA,  1'b1, 1'b0},
        '{4'd5, PIN_DATA,  1'b1, 1'b0},
        '{4'd6, PIN_DATA,  1'b1, 1'b0},
        '{4'd7, PIN_DATA,  1'b1, 1'b0},
        '{4'd8, PIN_DATA,  1'b1, 1'b0},
        '{4'd9, PIN_MARK,  1'b0, 1'b0},  // last data bit ends: stop bit
        '{4'd0, PIN_SPACE, 1'b0, 1'b1}   // stop bit ends: next byte or finish
    };

    function automatic logic [LIMIT_W-1:0] pow10(input int n);
        logic [LIMIT_W-1:0] acc;
        acc = LIMIT_W'(1);
        for (int i = 0; i < n; i++)
        begin
            acc = acc * LIMIT_W'(10);
        end
        return acc;
    endfunction

endpackage

### rtl/core/radio_frequency_command_serializer.sv
// Top level: APB register file, request channel, sequencer, converter and result register.
// One item per clock unless a held result stalls; each result shows in the next cycle.
// The sequencer settles a tick or request combinationally through its control ROM.
// The decimal conversion runs in the background while the cleanup string is sent.
// Reset (rst_n low, asynchronous) clears the registers, the sequencer and the result valid.
// Stored digits are not cleared; they are written by every accepted request.
module radio_frequency_command_serializer
    import rfcs_pkg::*;
#(
    parameter int NUM_DIGITS = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req_data,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             link_enable_reg, link_enable_next;
    logic [TPB_W-1:0] ticks_per_bit_reg, ticks_per_bit_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_data_reg, res_data_next;

    logic                       item_en;
    logic                       conv_start;
    res_t                       seq_result;
    cfg_t                       cfg;
    logic [NUM_DIGITS-1:0][3:0] digits;

    assign pready    = 1'b1;
    assign req_ready = !res_valid_reg || res_ready;
    assign item_en   = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;
    assign cfg       = '{link_enable: link_enable_reg, ticks_per_bit: ticks_per_bit_reg};

    always_comb
    begin
        link_enable_next   = link_enable_reg;
        ticks_per_bit_next = ticks_per_bit_reg;
        if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_LINK_ENABLE:   link_enable_next   = pwdata[0];
                REG_TICKS_PER_BIT: ticks_per_bit_next = pwdata[TPB_W-1:0];
                default:           link_enable_next   = link_enable_reg;
            endcase
        end

        unique case (paddr[2])
            REG_LINK_ENABLE:   prdata = {31'b0, link_enable_reg};
            REG_TICKS_PER_BIT: prdata = {16'b0, ticks_per_bit_reg};
            default:           prdata = '0;
        endcase
    end

    // The result register is the only buffer; a new item may enter as the old result leaves.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (item_en)
        begin
            res_valid_next = 1'b1;
            res_data_next  = seq_result;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    rfcs_seq #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_en    (item_en),
        .item       (req_data),
        .cfg        (cfg),
        .digits     (digits),
        .conv_start (conv_start),
        .result     (seq_result)
    );

    rfcs_bcd_conv #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .value  (req_data.freq_hz),
        .digits (digits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_enable_reg   <= 1'b0;
            ticks_per_bit_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            link_enable_reg   <= link_enable_next;
            ticks_per_bit_reg <= ticks_per_bit_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

endmodule

### rtl/core/rfcs_bcd_conv.sv
// Iterative binary to decimal converter: one shift-and-correct step per clock.
module rfcs_bcd_conv
    import rfcs_pkg::*;
#(
    parameter int NUM_DIGITS = 11
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [FREQ_W-1:0]           value,
    output logic [NUM_DIGITS-1:0][3:0]  digits
);

    localparam logic [LIMIT_W-1:0] LIMIT = pow10(NUM_DIGITS) - LIMIT_W'(1);
    localparam int CNT_W = $clog2(FREQ_W + 1);

    logic [FREQ_W-1:0]          bin_reg, bin_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_reg, bcd_next;
    logic [NUM_DIGITS-1:0][3:0] bcd_adj;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [FREQ_W-1:0]          value_sat;

    always_comb
    begin
        if ({(LIMIT_W - FREQ_W)'(0), value} > LIMIT)
        begin
            value_sat = LIMIT[FREQ_W-1:0];
        end
        else
        begin
            value_sat = value;
        end

        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end

        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        if (start)
        begin
            bin_next   = value_sat;
            bcd_next   = '0;
            count_next = CNT_W'(FREQ_W);
        end
        else if (count_reg != '0)
        begin
            // The saturated value never shifts a set bit out of the top of the most significant digit.
            bcd_next   = {bcd_adj[NUM_DIGITS-1][2:0], bcd_adj[NUM_DIGITS-2:0],
                          bin_reg[FREQ_W-1]};
            bin_next   = {bin_reg[FREQ_W-2:0], 1'b0};
            count_next = count_reg - CNT_W'(1);
        end

        // Digit 0 is the most significant one.
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digits[i] = bcd_reg[NUM_DIGITS-1-i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

### rtl/core/rfcs_seq.sv
// Microcoded bit sequencer: step counter, control ROM, tick counter and byte shifter.
module rfcs_seq
    import rfcs_pkg::*;
#(
    parameter int NUM_DIGITS = 11
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_en,
    input  req_t                        item,
    input  cfg_t                        cfg,
    input  logic [NUM_DIGITS-1:0][3:0]  digits,
    output logic                        conv_start,
    output res_t                        result
);

    localparam int MSG_LEN = CLEAN_LEN + 4 + NUM_DIGITS;
    localparam int IDX_W   = $clog2(NUM_DIGITS);

    logic [TPB_W-1:0]      tick_count_reg, tick_count_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [BYTE_POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  sending_reg, sending_next;
    logic                  pin_reg, pin_next;

    ucode_t                uword;
    logic [TPB_W:0]        cnt;
    logic [BYTE_POS_W-1:0] pos_n;
    logic [BYTE_POS_W-1:0] didx;
    logic [7:0]            next_char;
    logic                  pin_bit;
    logic                  done;
    logic                  rejected;

    always_comb
    begin
        uword = UCODE_ROM[step_reg];
        cnt   = {1'b0, tick_count_reg} + (TPB_W + 1)'(1);
        pos_n = byte_pos_reg + BYTE_POS_W'(1);
        didx  = pos_n - BYTE_POS_W'(CLEAN_LEN + 3);

        if (pos_n < BYTE_POS_W'(CLEAN_LEN))
        begin
            next_char = CLEAN_STR[pos_n[4:0]];
        end
        else if (pos_n == BYTE_POS_W'(CLEAN_LEN + 1))
        begin
            next_char = CHAR_F;
        end
        else if (pos_n == BYTE_POS_W'(CLEAN_LEN + 2))
        begin
            next_char = CHAR_A;
        end
        else if ((pos_n > BYTE_POS_W'(CLEAN_LEN + 2)) &&
                 (pos_n < BYTE_POS_W'(CLEAN_LEN + 3 + NUM_DIGITS)))
        begin
            next_char = {DIGIT_HIGH, digits[didx[IDX_W-1:0]]};
        end
        else
        begin
            next_char = CHAR_SEMI;
        end

        unique case (uword.pin_sel)
            PIN_MARK:  pin_bit = 1'b0;
            PIN_SPACE: pin_bit = 1'b1;
            PIN_DATA:  pin_bit = ~shift_reg[0];
            default:   pin_bit = 1'b0;
        endcase

        tick_count_next = tick_count_reg;
        step_next       = step_reg;
        byte_pos_next   = byte_pos_reg;
        shift_next      = shift_reg;
        sending_next    = sending_reg;
        pin_next        = pin_reg;
        done            = 1'b0;
        rejected        = 1'b0;
        conv_start      = 1'b0;

        if (item_en)
        begin
            if (item.mode == MODE_REQUEST)
            begin
                if (!cfg.link_enable || (cfg.ticks_per_bit == '0) || sending_reg)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    conv_start      = 1'b1;
                    sending_next    = 1'b1;
                    byte_pos_next   = '0;
                    step_next       = STEP_START;
                    tick_count_next = '0;
                    shift_next      = CLEAN_STR[0];
                    pin_next        = 1'b1;
                end
            end
            else if ((item.mode == MODE_TICK) && sending_reg)
            begin
                if (cnt >= {1'b0, cfg.ticks_per_bit})
                begin
                    tick_count_next = '0;
                    step_next       = uword.next_step;
                    if (uword.end_of_byte &&
                        (byte_pos_reg == BYTE_POS_W'(MSG_LEN - 1)))
                    begin
                        sending_next  = 1'b0;
                        byte_pos_next = '0;
                        step_next     = STEP_START;
                        pin_next      = 1'b0;
                        done          = 1'b1;
                    end
                    else
                    begin
                        pin_next = pin_bit;
                        if (uword.end_of_byte)
                        begin
                            byte_pos_next = pos_n;
                            shift_next    = next_char;
                        end
                        else if (uword.shift_en)
                        begin
                            shift_next = {1'b0, shift_reg[7:1]};
                        end
                    end
                end
                else
                begin
                    tick_count_next = cnt[TPB_W-1:0];
                end
            end
        end

        result.line_level       = pin_next;
        result.busy_res         = sending_next;
        result.sequence_done    = done;
        result.request_rejected = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            step_reg       <= STEP_START;
            byte_pos_reg   <= '0;
            shift_reg      <= '0;
            sending_reg    <= 1'b0;
            pin_reg        <= 1'b0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            step_reg       <= step_next;
            byte_pos_reg   <= byte_pos_next;
            shift_reg      <= shift_next;
            sending_reg    <= sending_next;
            pin_reg        <= pin_next;
        end
    end

endmodule

### rtl/core/rfcs_checker.sv
// Port-level checker for the command serializer and the bind that attaches it.
module rfcs_checker
    import rfcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input req_t        req_data,
    input logic        res_valid,
    input logic        res_ready,
    input res_t        res_data,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled result transfer keeps its valid and its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // The line rests low, at the mark level, whenever no sequence is running.
    a_idle_line: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.busy_res |-> !res_data.line_level)
        else $error("line active while idle");

    // The tick that ends the sequence leaves the block idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.sequence_done |-> !res_data.busy_res)
        else $error("busy after sequence end");

    // A refused request cannot also be the tick that finishes a sequence.
    a_reject_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.request_rejected |-> !res_data.sequence_done)
        else $error("reject and done together");

    // A result that leaves while no new transfer arrives frees the output register.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !(req_valid && req_ready) |=> req_ready)
        else $error("input not ready after result drained");

endmodule

bind radio_frequency_command_serializer rfcs_checker u_checker (.*);
